// File: hdl/stepper_pulse_ramp_generator_top_assert.svh
// Assertion macros for the step-pulse ramp generator.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef STEPPER_PULSE_RAMP_GENERATOR_TOP_ASSERT_SVH
`define STEPPER_PULSE_RAMP_GENERATOR_TOP_ASSERT_SVH

// Check that a condition holds at every edge.
`define SPRG_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("step pulse generator: invariant violated");

// Check that a condition is followed by another on the next edge.
`define SPRG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("step pulse generator: sequence violated");

`endif

// File: hdl/sprg_pkg.sv
// ----------------------------------------------------------------------------
// sprg_pkg
// Shared constants, codes and payload types of the step-pulse ramp generator.
// ----------------------------------------------------------------------------
package sprg_pkg;

    localparam int MOTOR_COUNT = 5;
    localparam int COUNT_WIDTH = 16;
    localparam int PIN_W       = 5;
    localparam int MASK_W      = 5;
    localparam int IDX_W       = $clog2(MOTOR_COUNT + 1);

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_MOVE = 1'b1;

    typedef enum logic [1:0] {
        PH_FALL = 2'd0,
        PH_HOLD = 2'd1,
        PH_RISE = 2'd2
    } phase_t;

    typedef struct packed {
        logic                   op;
        logic [MASK_W-1:0]      motor_mask;
        logic                   direction;
        logic [COUNT_WIDTH-1:0] step_count;
        logic [COUNT_WIDTH-1:0] ramp_count;
        logic [COUNT_WIDTH-1:0] fast_delay;
        logic [COUNT_WIDTH-1:0] slow_delay;
        logic                   use_ramp;
    } cmd_t;

    typedef struct packed {
        logic [PIN_W-1:0] enable_pins_n;
        logic [PIN_W-1:0] dir_pins;
        logic [PIN_W-1:0] step_pins;
        logic             busy_res;
        logic             done_res;
        logic             rejected;
    } res_t;

endpackage

// File: hdl/sprg_if.sv
// ----------------------------------------------------------------------------
// sprg_cmd_if / sprg_res_if
// Valid/ready channels carrying command requests and pin-state results.
// ----------------------------------------------------------------------------
interface sprg_cmd_if;
    logic          valid;
    logic          ready;
    sprg_pkg::cmd_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sprg_res_if;
    logic          valid;
    logic          ready;
    sprg_pkg::res_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/stepper_pulse_ramp_generator_top.sv
// ----------------------------------------------------------------------------
// stepper_pulse_ramp_generator_top
// Step-pulse generator with linear speed ramp for five stepper drivers.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one request per item: a one-microsecond tick or a move
//   command (mask, direction, counts, fast/slow half-periods, ramp enable).
//   res returns exactly one result per request: enable, direction and step
//   pin levels plus busy, done and rejected flags.
//   The result of a request accepted at one edge is registered and is
//   valid after that edge unless res stalls. A request can be accepted in
//   every cycle while cmd.ready is high; the state update is combinational
//   and folds the next motor search and the delay-level change into one pass.
//   When res stalls, results queue in an output register and a skid
//   register; cmd.ready drops only while both are full, and rises again
//   right after the edge at which res takes a result.
//   Reset drives all enables high (inactive), clears directions, step pins
//   and the move state, and empties the result queue. No clearing pass.
//   A move request arriving while a move runs is answered with rejected.
// ----------------------------------------------------------------------------
`include "stepper_pulse_ramp_generator_top_assert.svh"

module stepper_pulse_ramp_generator_top (
    input  logic              clk,
    input  logic              rst_n,
    sprg_cmd_if.sink          cmd,
    sprg_res_if.source        res
);

    localparam int MC = sprg_pkg::MOTOR_COUNT;
    localparam int CW = sprg_pkg::COUNT_WIDTH;
    localparam int IW = sprg_pkg::IDX_W;

    logic [MC-1:0]          enable_reg, enable_next;
    logic [MC-1:0]          dir_reg, dir_next;
    logic [MC-1:0]          step_reg, step_next;
    logic                   busy_reg, busy_next;
    sprg_pkg::phase_t       phase_reg, phase_next;
    logic [CW-1:0]          delay_reg, delay_next;
    logic [CW-1:0]          reps_reg, reps_next;
    logic [IW-1:0]          motor_reg, motor_next;
    logic                   half_reg, half_next;
    logic [CW-1:0]          tick_reg, tick_next;
    logic [MC-1:0]          mask_reg, mask_next;
    logic [CW-1:0]          stepc_reg, stepc_next;
    logic [CW-1:0]          ramp_reg, ramp_next;
    logic [CW-1:0]          fast_reg, fast_next;
    logic [CW-1:0]          slow_reg, slow_next;

    logic                   out_valid_reg, out_valid_next;
    sprg_pkg::res_t         out_data_reg, out_data_next;
    logic                   skid_valid_reg, skid_valid_next;
    sprg_pkg::res_t         skid_data_reg, skid_data_next;

    logic                   accept;
    logic                   start;
    logic                   done;
    logic                   rej;
    sprg_pkg::res_t         res_next;

    logic [MC-1:0]          in_mask;
    logic [CW-1:0]          in_ramp;

    sprg_pkg::phase_t       sk_phase;
    logic [CW-1:0]          sk_delay;
    logic [CW-1:0]          sk_reps;
    logic [IW-1:0]          sk_from;
    logic [MC-1:0]          sk_mask;
    logic [CW-1:0]          sk_stepc;
    logic [CW-1:0]          sk_ramp;
    logic [CW-1:0]          sk_fast;
    logic [CW-1:0]          sk_slow;

    logic                   lvl_ok;
    sprg_pkg::phase_t       lvl_phase;
    logic [CW-1:0]          lvl_delay;
    logic [CW-1:0]          lvl_reps;

    logic [IW:0]            hit_from;
    logic [IW:0]            hit_low;

    logic                   seek_ok;
    sprg_pkg::phase_t       seek_phase;
    logic [CW-1:0]          seek_delay;
    logic [CW-1:0]          seek_reps;
    logic [IW-1:0]          seek_motor;

    logic [CW-1:0]          tick_dec;

    function automatic logic [IW:0] first_set(input logic [MC-1:0] mask,
                                              input logic [IW-1:0] from);
        logic          hit;
        logic [IW-1:0] idx;
        hit = 1'b0;
        idx = '0;
        for (int i = MC - 1; i >= 0; i--)
        begin
            if (mask[i] && (i >= int'(from)))
            begin
                hit = 1'b1;
                idx = IW'(i);
            end
        end
        return {hit, idx};
    endfunction

    function automatic logic [CW-1:0] eff_delay(input logic [CW-1:0] d);
        return (d == '0) ? CW'(1) : d;
    endfunction

    assign cmd.ready = !skid_valid_reg;
    assign accept    = cmd.valid && !skid_valid_reg;
    assign start     = accept && (cmd.data.op == sprg_pkg::OP_MOVE) && !busy_reg;
    assign in_mask   = cmd.data.motor_mask[MC-1:0];
    assign in_ramp   = cmd.data.use_ramp ? cmd.data.ramp_count : '0;
    assign tick_dec  = tick_reg - CW'(1);

    // Seek inputs: fresh command on start, saved move otherwise.
    always_comb
    begin
        if (start)
        begin
            sk_mask  = in_mask;
            sk_stepc = cmd.data.step_count;
            sk_ramp  = in_ramp;
            sk_fast  = cmd.data.fast_delay;
            sk_slow  = cmd.data.slow_delay;
            sk_from  = '0;
            if ((in_ramp != '0) && (cmd.data.slow_delay > cmd.data.fast_delay))
            begin
                sk_phase = sprg_pkg::PH_FALL;
                sk_delay = cmd.data.slow_delay;
                sk_reps  = in_ramp;
            end
            else
            begin
                sk_phase = sprg_pkg::PH_HOLD;
                sk_delay = cmd.data.fast_delay;
                sk_reps  = cmd.data.step_count;
            end
        end
        else
        begin
            sk_mask  = mask_reg;
            sk_stepc = stepc_reg;
            sk_ramp  = ramp_reg;
            sk_fast  = fast_reg;
            sk_slow  = slow_reg;
            sk_from  = motor_reg + IW'(1);
            sk_phase = phase_reg;
            sk_delay = delay_reg;
            sk_reps  = reps_reg;
        end
    end

    // Next delay level once the repetitions of the current one run out.
    always_comb
    begin
        lvl_ok    = 1'b0;
        lvl_phase = sk_phase;
        lvl_delay = sk_delay;
        lvl_reps  = sk_reps;
        unique case (sk_phase)
            sprg_pkg::PH_FALL:
            begin
                if ((sk_ramp != '0) && ((sk_delay - CW'(1)) > sk_fast))
                begin
                    lvl_ok    = 1'b1;
                    lvl_delay = sk_delay - CW'(1);
                    lvl_reps  = sk_ramp;
                end
                else if (sk_stepc != '0)
                begin
                    lvl_ok    = 1'b1;
                    lvl_phase = sprg_pkg::PH_HOLD;
                    lvl_delay = sk_fast;
                    lvl_reps  = sk_stepc;
                end
                else if ((sk_ramp != '0) && (sk_fast < sk_slow))
                begin
                    lvl_ok    = 1'b1;
                    lvl_phase = sprg_pkg::PH_RISE;
                    lvl_delay = sk_fast;
                    lvl_reps  = sk_ramp;
                end
            end
            sprg_pkg::PH_HOLD:
            begin
                if ((sk_ramp != '0) && (sk_fast < sk_slow))
                begin
                    lvl_ok    = 1'b1;
                    lvl_phase = sprg_pkg::PH_RISE;
                    lvl_delay = sk_fast;
                    lvl_reps  = sk_ramp;
                end
            end
            sprg_pkg::PH_RISE:
            begin
                if (({1'b0, sk_delay} + (CW + 1)'(1)) < {1'b0, sk_slow})
                begin
                    lvl_ok    = 1'b1;
                    lvl_delay = sk_delay + CW'(1);
                    lvl_reps  = sk_ramp;
                end
            end
            default:
            begin
                lvl_ok = 1'b0;
            end
        endcase
    end

    assign hit_from = first_set(sk_mask, sk_from);
    assign hit_low  = first_set(sk_mask, '0);

    // Next motor visit: same repetition, next repetition, or next level.
    always_comb
    begin
        seek_ok    = 1'b0;
        seek_phase = sk_phase;
        seek_delay = sk_delay;
        seek_reps  = sk_reps;
        seek_motor = hit_low[IW-1:0];
        if (sk_mask == '0)
        begin
            seek_ok = 1'b0;
        end
        else if ((sk_reps != '0) && hit_from[IW])
        begin
            seek_ok    = 1'b1;
            seek_motor = hit_from[IW-1:0];
        end
        else if ((sk_reps != '0) && (sk_reps != CW'(1)))
        begin
            seek_ok   = 1'b1;
            seek_reps = sk_reps - CW'(1);
        end
        else
        begin
            seek_ok    = lvl_ok;
            seek_phase = lvl_phase;
            seek_delay = lvl_delay;
            seek_reps  = lvl_reps;
        end
    end

    // Move state update.
    always_comb
    begin
        enable_next = enable_reg;
        dir_next    = dir_reg;
        step_next   = step_reg;
        busy_next   = busy_reg;
        phase_next  = phase_reg;
        delay_next  = delay_reg;
        reps_next   = reps_reg;
        motor_next  = motor_reg;
        half_next   = half_reg;
        tick_next   = tick_reg;
        mask_next   = mask_reg;
        stepc_next  = stepc_reg;
        ramp_next   = ramp_reg;
        fast_next   = fast_reg;
        slow_next   = slow_reg;
        done        = 1'b0;
        rej         = 1'b0;

        if (accept && (cmd.data.op == sprg_pkg::OP_MOVE) && busy_reg)
        begin
            rej = 1'b1;
        end
        else if (start || (accept && busy_reg && (tick_dec == '0) && half_reg))
        begin
            if (start)
            begin
                enable_next = enable_reg & ~in_mask;
                dir_next    = cmd.data.direction ? (dir_reg | in_mask)
                                                 : (dir_reg & ~in_mask);
                mask_next   = in_mask;
                stepc_next  = cmd.data.step_count;
                ramp_next   = in_ramp;
                fast_next   = cmd.data.fast_delay;
                slow_next   = cmd.data.slow_delay;
            end
            phase_next = seek_phase;
            delay_next = seek_delay;
            reps_next  = seek_reps;
            motor_next = seek_motor;
            if (seek_ok)
            begin
                busy_next = 1'b1;
                step_next = MC'(1) << seek_motor;
                half_next = 1'b0;
                tick_next = eff_delay(seek_delay);
            end
            else
            begin
                busy_next  = 1'b0;
                step_next  = '0;
                phase_next = sprg_pkg::PH_FALL;
                half_next  = 1'b0;
                tick_next  = '0;
                done       = 1'b1;
            end
        end
        else if (accept && busy_reg)
        begin
            if (tick_dec == '0)
            begin
                step_next = '0;
                half_next = 1'b1;
                tick_next = eff_delay(delay_reg);
            end
            else
            begin
                tick_next = tick_dec;
            end
        end
    end

    always_comb
    begin
        res_next.enable_pins_n = sprg_pkg::PIN_W'(enable_next);
        res_next.dir_pins      = sprg_pkg::PIN_W'(dir_next);
        res_next.step_pins     = sprg_pkg::PIN_W'(step_next);
        res_next.busy_res      = busy_next;
        res_next.done_res      = done;
        res_next.rejected      = rej;
    end

    // Result queue: output register backed by a skid register.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || res.ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = accept;
                out_data_next  = res_next;
            end
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res_next;
        end
    end

    assign res.valid = out_valid_reg;
    assign res.data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= '1;
            dir_reg        <= '0;
            step_reg       <= '0;
            busy_reg       <= 1'b0;
            phase_reg      <= sprg_pkg::PH_FALL;
            delay_reg      <= '0;
            reps_reg       <= '0;
            motor_reg      <= '0;
            half_reg       <= 1'b0;
            tick_reg       <= '0;
            mask_reg       <= '0;
            stepc_reg      <= '0;
            ramp_reg       <= '0;
            fast_reg       <= '0;
            slow_reg       <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            enable_reg     <= enable_next;
            dir_reg        <= dir_next;
            step_reg       <= step_next;
            busy_reg       <= busy_next;
            phase_reg      <= phase_next;
            delay_reg      <= delay_next;
            reps_reg       <= reps_next;
            motor_reg      <= motor_next;
            half_reg       <= half_next;
            tick_reg       <= tick_next;
            mask_reg       <= mask_next;
            stepc_reg      <= stepc_next;
            ramp_reg       <= ramp_next;
            fast_reg       <= fast_next;
            slow_reg       <= slow_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    `SPRG_ASSERT_ALWAYS(a_step_onehot, $onehot0(step_reg) && ((step_reg == '0) || busy_reg))
    `SPRG_ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_reg || out_valid_reg)
    `SPRG_ASSERT_NEXT(a_skid_holds, skid_valid_reg && !res.ready, skid_valid_reg)
    `SPRG_ASSERT_NEXT(a_enable_stays, 1'b1, (enable_reg & ~$past(enable_reg)) == '0)

endmodule
